// ===== hdl/mmt_pkg.sv =====
// Shared types, register codes and constants for the market-maker tick engine.
package mmt_pkg;

    localparam int EXP_DEPTH_DEF = 256;
    localparam int FRAC_W        = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [31:0] MID_FLOOR = 32'd655;
    localparam logic [31:0] MID_RESET = 32'd6553600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_WIDTH     = 3'd0,
        REG_SKEW_PER_UNIT  = 3'd1,
        REG_ARRIVAL_PROB   = 3'd2,
        REG_INFORMED_PROB  = 3'd3,
        REG_FILL_SCALE     = 3'd4,
        REG_FEE_PER_FILL   = 3'd5,
        REG_INV_LIMIT      = 3'd6,
        REG_START_MIDPRICE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [23:0] price_move;
        logic [15:0]        arrival_draw;
        logic [15:0]        informed_draw;
        logic [15:0]        side_draw;
        logic [15:0]        fill_draw;
    } t_in;

    typedef struct packed {
        logic signed [31:0] bid_price;
        logic signed [31:0] ask_price;
        logic               filled;
        logic               fill_side;
        logic signed [11:0] position;
        logic signed [47:0] cash_balance;
        logic [31:0]        fill_count;
        logic [47:0]        adverse_cost;
        logic [31:0]        midprice_out;
        logic signed [47:0] profit;
    } t_out;

    typedef struct packed {
        logic [19:0] half_width;
        logic [15:0] skew_per_unit;
        logic [16:0] arrival_prob;
        logic [16:0] informed_prob;
        logic [16:0] fill_scale;
        logic [15:0] fee_per_fill;
        logic [9:0]  inv_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        half_width:    20'd6881,
        skew_per_unit: 16'd983,
        arrival_prob:  17'd26214,
        informed_prob: 17'd13107,
        fill_scale:    17'd49152,
        fee_per_fill:  16'd131,
        inv_limit:     10'd20
    };

    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } t_mid_load;

    typedef struct packed {
        logic load_in;
        logic quote;
        logic addr;
        logic read;
        logic interp;
        logic scale;
        logic commit;
        logic prod;
        logic load_out;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUOTE,
        S_ADDR,
        S_READ,
        S_INTERP,
        S_SCALE,
        S_COMMIT,
        S_PROD,
        S_DONE
    } t_state;

endpackage

// ===== hdl/mmt_exp_rom.sv =====
// Exp(-8d) lookup table in two banks, registered read of two neighboring entries.
module mmt_exp_rom
    import mmt_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
)
(
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] i_idx,
    output logic [16:0]                        o_lo,
    output logic [16:0]                        o_hi
);

    localparam int IdxW      = $clog2(EXP_TABLE_DEPTH);
    localparam int EvenDepth = EXP_TABLE_DEPTH / 2 + 1;
    localparam int OddDepth  = (EXP_TABLE_DEPTH + 1) / 2;
    localparam int EvenAw    = $clog2(EvenDepth);
    localparam int OddAw     = $clog2(OddDepth);

    // Shift-subtract quotient, evaluated only while the table is built.
    function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry is 1/exp(16*pos/depth) in Q0.16, from a truncated Taylor sum in Q24.
    function automatic logic [16:0] exp_entry(input int unsigned pos);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] num;
        term = 64'd1 << 24;
        sum  = term;
        for (int unsigned k = 1; k < 200; k++) begin
            if (term != 64'd0) begin
                term = div_floor(term * 64'(16 * pos), 64'(EXP_TABLE_DEPTH) * 64'(k));
                sum  = sum + term;
            end
        end
        num = (64'd1 << 40) + (sum >> 1);
        return 17'(div_floor(num, sum));
    endfunction

    logic [16:0] even_tab [EvenDepth];
    logic [16:0] odd_tab  [OddDepth];

    for (genvar g = 0; g < EvenDepth; g++) begin : g_even
        localparam logic [16:0] EntryVal = exp_entry(2 * g);
        assign even_tab[g] = EntryVal;
    end

    for (genvar g = 0; g < OddDepth; g++) begin : g_odd
        localparam logic [16:0] EntryVal = exp_entry(2 * g + 1);
        assign odd_tab[g] = EntryVal;
    end

    logic [IdxW:0]     idx_p1;
    logic [EvenAw-1:0] even_addr;
    logic [OddAw-1:0]  odd_addr;

    // Entries idx and idx+1 always sit in opposite banks.
    assign idx_p1    = {1'b0, i_idx} + {{IdxW{1'b0}}, 1'b1};
    assign even_addr = idx_p1[EvenAw:1];
    assign odd_addr  = i_idx[OddAw:1];

    logic [16:0] r_even;
    logic [16:0] r_odd;
    logic        r_odd_first;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_even      <= even_tab[even_addr];
            r_odd       <= odd_tab[odd_addr];
            r_odd_first <= i_idx[0];
        end
    end

    assign o_lo = r_odd_first ? r_odd  : r_even;
    assign o_hi = r_odd_first ? r_even : r_odd;

endmodule

// ===== hdl/mmt_regs.sv =====
// Configuration register file with the midprice load strobe.
module mmt_regs
    import mmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output t_mid_load             o_mid_load
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg            = r_cfg;
        o_mid_load.load  = 1'b0;
        o_mid_load.value = (i_cfg_data < MID_FLOOR) ? MID_FLOOR : i_cfg_data;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HALF_WIDTH:     n_cfg.half_width    = i_cfg_data[19:0];
                REG_SKEW_PER_UNIT:  n_cfg.skew_per_unit = i_cfg_data[15:0];
                REG_ARRIVAL_PROB:   n_cfg.arrival_prob  = i_cfg_data[16:0];
                REG_INFORMED_PROB:  n_cfg.informed_prob = i_cfg_data[16:0];
                REG_FILL_SCALE:     n_cfg.fill_scale    = i_cfg_data[16:0];
                REG_FEE_PER_FILL:   n_cfg.fee_per_fill  = i_cfg_data[15:0];
                REG_INV_LIMIT:      n_cfg.inv_limit     = i_cfg_data[9:0];
                REG_START_MIDPRICE: o_mid_load.load     = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/mmt_ctrl.sv =====
// Tick sequencer: steps the datapath through one tick and owns the result handshake.
module mmt_ctrl
    import mmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        out_free   = !r_out_valid || i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_QUOTE;
                end
            end
            S_QUOTE: begin
                o_cmd.quote = 1'b1;
                n_state     = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees, then take the next tick at once
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_in_ready     = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load_in = 1'b1;
                        n_state       = S_QUOTE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/mmt_dp.sv =====
// Tick datapath: quotes, fill chance, position and accumulator state, result register.
module mmt_dp
    import mmt_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_cfg      i_cfg,
    input  t_mid_load i_mid_load,
    input  t_in       i_in,
    output t_out      o_out
);

    localparam int IdxW = $clog2(EXP_TABLE_DEPTH);
    localparam int PosW = FRAC_W + IdxW;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            return v[47:0];
        end
        return v[49] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            return v[31:0];
        end
        return v[34] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    endfunction

    // architectural state
    logic [31:0]        r_mid;
    logic signed [11:0] r_inv;
    logic signed [47:0] r_cash;
    logic [31:0]        r_fills;
    logic [47:0]        r_adverse;

    // per-tick working registers
    t_in                r_in;
    logic signed [28:0] r_skinv;
    logic               r_arrive;
    logic               r_buy;
    logic [31:0]        r_newmid;
    logic signed [34:0] r_bid;
    logic signed [34:0] r_ask;
    logic [IdxW-1:0]    r_idx;
    logic [FRAC_W-1:0]  r_frac;
    logic               r_far;
    logic [16:0]        r_value;
    logic               r_fill;
    logic               r_filled;
    logic               r_side;
    logic signed [44:0] r_mark;
    t_out               r_out;

    logic [16:0] rom_lo;
    logic [16:0] rom_hi;

    mmt_exp_rom #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_exp_rom (
        .i_clk(i_clk),
        .i_en (i_cmd.read),
        .i_idx(r_idx),
        .o_lo (rom_lo),
        .o_hi (rom_hi)
    );

    // quote step
    logic signed [28:0] skinv_c;
    logic signed [33:0] mid_sum_c;
    logic [31:0]        newmid_c;
    logic               arrive_c;
    logic               buy_c;

    always_comb begin
        skinv_c   = 29'($signed({1'b0, i_cfg.skew_per_unit})) * 29'(r_inv);
        mid_sum_c = $signed({2'b00, r_mid}) + 34'(r_in.price_move);
        if (mid_sum_c[33] || (!mid_sum_c[32] && mid_sum_c[31:0] < MID_FLOOR)) begin
            newmid_c = MID_FLOOR;
        end else if (mid_sum_c[32]) begin
            newmid_c = '1;
        end else begin
            newmid_c = mid_sum_c[31:0];
        end
        arrive_c = {1'b0, r_in.arrival_draw} < i_cfg.arrival_prob;
        // informed flow trades with the move, uninformed flow flips a coin
        if ({1'b0, r_in.informed_draw} < i_cfg.informed_prob) begin
            buy_c = !r_in.price_move[23];
        end else begin
            buy_c = !r_in.side_draw[15];
        end
    end

    // quote and table address step
    logic signed [34:0] res_c;
    logic signed [34:0] bid_c;
    logic signed [34:0] ask_c;
    logic signed [29:0] dist_c;
    logic [FRAC_W-1:0]  d_c;
    logic               far_c;
    logic [PosW-1:0]    pos_c;
    logic [IdxW-1:0]    idx_c;

    always_comb begin
        res_c = $signed({3'b000, r_mid}) - 35'(r_skinv);
        bid_c = res_c - $signed(35'(i_cfg.half_width));
        ask_c = res_c + $signed(35'(i_cfg.half_width));
        if (r_buy) begin
            dist_c = $signed(30'(i_cfg.half_width)) - 30'(r_skinv);
        end else begin
            dist_c = $signed(30'(i_cfg.half_width)) + 30'(r_skinv);
        end
        far_c = !dist_c[29] && (dist_c[28:FRAC_W] != '0);
        d_c   = dist_c[29] ? '0 : dist_c[FRAC_W-1:0];
        pos_c = PosW'(d_c) * PosW'(EXP_TABLE_DEPTH);
        // a far quote reads the last entry as the upper neighbor
        idx_c = far_c ? IdxW'(EXP_TABLE_DEPTH - 1) : pos_c[PosW-1:FRAC_W];
    end

    // interpolation step
    logic        ge_c;
    logic [16:0] diff_c;
    logic [33:0] step_prod_c;
    logic [16:0] value_c;

    always_comb begin
        ge_c        = rom_lo >= rom_hi;
        diff_c      = ge_c ? rom_lo - rom_hi : rom_hi - rom_lo;
        step_prod_c = 34'(diff_c) * 34'(r_frac);
        if (r_far) begin
            value_c = rom_hi;
        end else if (ge_c) begin
            value_c = rom_lo - step_prod_c[33:FRAC_W];
        end else begin
            value_c = rom_lo + step_prod_c[33:FRAC_W];
        end
    end

    // fill chance step; a chance above one needs no clamp since draws stay below one
    logic [33:0] scaled_c;
    logic        fill_c;

    always_comb begin
        scaled_c = 34'(i_cfg.fill_scale) * 34'(r_value);
        fill_c   = r_arrive && ({2'b00, r_in.fill_draw} < scaled_c[33:16]);
    end

    // state update step
    logic signed [11:0] maxi_c;
    logic               filled_c;
    logic signed [11:0] n_inv;
    logic signed [49:0] cash_sum_c;
    logic signed [47:0] n_cash;
    logic [23:0]        adv_add_c;
    logic [48:0]        adv_sum_c;
    logic [47:0]        n_adverse;
    logic [31:0]        n_fills;

    always_comb begin
        maxi_c   = $signed({2'b00, i_cfg.inv_limit});
        filled_c = r_fill && (r_buy ? (r_inv > -maxi_c) : (r_inv < maxi_c));
        n_inv    = r_buy ? r_inv - 12'sd1 : r_inv + 12'sd1;
        if (r_buy) begin
            cash_sum_c = 50'(r_cash) + 50'(r_ask) - $signed(50'(i_cfg.fee_per_fill));
        end else begin
            cash_sum_c = 50'(r_cash) - 50'(r_bid) - $signed(50'(i_cfg.fee_per_fill));
        end
        n_cash = sat48(cash_sum_c);
        // charge the move that went against the fill
        if (r_buy) begin
            adv_add_c = (!r_in.price_move[23] && r_in.price_move != '0) ? r_in.price_move : '0;
        end else begin
            adv_add_c = r_in.price_move[23] ? -r_in.price_move : '0;
        end
        adv_sum_c = {1'b0, r_adverse} + 49'(adv_add_c);
        n_adverse = adv_sum_c[48] ? '1 : adv_sum_c[47:0];
        n_fills   = (r_fills == '1) ? r_fills : r_fills + 32'd1;
    end

    // mark-to-market and result
    logic signed [44:0] mark_c;
    t_out               n_out;

    always_comb begin
        mark_c             = 45'(r_inv) * $signed({13'b0, r_mid});
        n_out.bid_price    = sat32(r_bid);
        n_out.ask_price    = sat32(r_ask);
        n_out.filled       = r_filled;
        n_out.fill_side    = r_side;
        n_out.position     = r_inv;
        n_out.cash_balance = r_cash;
        n_out.fill_count   = r_fills;
        n_out.adverse_cost = r_adverse;
        n_out.midprice_out = r_mid;
        n_out.profit       = sat48(50'(r_cash) + 50'(r_mark));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= MID_RESET;
            r_inv     <= '0;
            r_cash    <= '0;
            r_fills   <= '0;
            r_adverse <= '0;
        end else begin
            if (i_mid_load.load) begin
                r_mid <= i_mid_load.value;
            end else if (i_cmd.commit) begin
                r_mid <= r_newmid;
            end
            if (i_cmd.commit && filled_c) begin
                r_inv     <= n_inv;
                r_cash    <= n_cash;
                r_fills   <= n_fills;
                r_adverse <= n_adverse;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.quote) begin
            r_skinv  <= skinv_c;
            r_arrive <= arrive_c;
            r_buy    <= buy_c;
            r_newmid <= newmid_c;
        end
        if (i_cmd.addr) begin
            r_bid  <= bid_c;
            r_ask  <= ask_c;
            r_idx  <= idx_c;
            r_frac <= pos_c[FRAC_W-1:0];
            r_far  <= far_c;
        end
        if (i_cmd.interp) begin
            r_value <= value_c;
        end
        if (i_cmd.scale) begin
            r_fill <= fill_c;
        end
        if (i_cmd.commit) begin
            r_filled <= filled_c;
            r_side   <= filled_c && r_buy;
        end
        if (i_cmd.prod) begin
            r_mark <= mark_c;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// ===== hdl/market_maker_tick_step.sv =====
// Top level of the inventory-skewed market-making tick engine.
//
//   channel   direction  handshake                    payload
//   in        sink       i_in_valid / o_in_ready      i_in_data  (t_in, one tick)
//   out       source     o_out_valid / i_out_ready    o_out_data (t_out, one result)
//   cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A tick runs from transfer in to result loaded through these steps: skew multiply, quote and
// table address, registered table read, interpolation multiply, fill-scale multiply,
// state update, mark-to-market multiply, result load. The sequencer runs one tick at a
// time; the next tick transfers in the cycle its predecessor's result is loaded.
// The result register stalls the sequencer only when the previous result is still held.
// Reset is synchronous, active low: state and settings take defaults, midprice 6553600.
module market_maker_tick_step
    import mmt_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd      cmd;
    t_cfg      cfg;
    t_mid_load mid_load;

    assign o_cfg_ready = 1'b1;

    mmt_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_mid_load (mid_load)
    );

    mmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_ready(i_out_ready),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (cmd)
    );

    mmt_dp #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (cfg),
        .i_mid_load(mid_load),
        .i_in      (i_in_data),
        .o_out     (o_out_data)
    );

endmodule

// ===== bench/tb_market_maker_tick_step.sv =====
// Self-checking bench for the market-maker tick engine: random ticks and settings vs a predictor.
module tb_market_maker_tick_step;
    import mmt_pkg::*;

    class quote_scoreboard;
        t_out        pending_quotes[$];
        int          errors;
        int unsigned n_checked;
        logic [63:0] exp_tab [0:EXP_DEPTH_DEF];

        logic [19:0] half_width;
        logic [15:0] skew_per_unit;
        logic [16:0] arrival_prob;
        logic [16:0] informed_prob;
        logic [16:0] fill_scale;
        logic [15:0] fee_per_fill;
        logic [9:0]  inv_limit;

        logic [31:0] mid;
        longint      inv;
        longint      cash;
        longint      adverse;
        logic [31:0] fills;

        function new();
            logic [63:0] term;
            logic [63:0] total;
            // exp(-8d) in Q0.16 as the reciprocal of a truncated Taylor sum of exp(+8d)
            for (int i = 0; i <= EXP_DEPTH_DEF; i++) begin
                term  = 64'd1 << 24;
                total = term;
                for (int k = 1; k < 200 && term != 0; k++) begin
                    term  = term * (16 * i) / (EXP_DEPTH_DEF * k);
                    total += term;
                end
                exp_tab[i] = ((64'd1 << 40) + total / 2) / total;
            end
            half_width    = CFG_RESET.half_width;
            skew_per_unit = CFG_RESET.skew_per_unit;
            arrival_prob  = CFG_RESET.arrival_prob;
            informed_prob = CFG_RESET.informed_prob;
            fill_scale    = CFG_RESET.fill_scale;
            fee_per_fill  = CFG_RESET.fee_per_fill;
            inv_limit     = CFG_RESET.inv_limit;
            mid       = MID_RESET;
            inv       = 0;
            cash      = 0;
            adverse   = 0;
            fills     = '0;
            errors    = 0;
            n_checked = 0;
        endfunction

        function void write_reg(t_reg_idx r, logic [31:0] v);
            case (r)
                REG_HALF_WIDTH:     half_width    = v[19:0];
                REG_SKEW_PER_UNIT:  skew_per_unit = v[15:0];
                REG_ARRIVAL_PROB:   arrival_prob  = v[16:0];
                REG_INFORMED_PROB:  informed_prob = v[16:0];
                REG_FILL_SCALE:     fill_scale    = v[16:0];
                REG_FEE_PER_FILL:   fee_per_fill  = v[15:0];
                REG_INV_LIMIT:      inv_limit     = v[9:0];
                REG_START_MIDPRICE: mid = (v < MID_FLOOR) ? MID_FLOOR : v;
                default: ;
            endcase
        endfunction

        function longint sat48(longint v);
            if (v > 64'sh0000_7FFF_FFFF_FFFF) return 64'sh0000_7FFF_FFFF_FFFF;
            if (v < -64'sh0000_8000_0000_0000) return -64'sh0000_8000_0000_0000;
            return v;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sh0000_0000_7FFF_FFFF) return 64'sh0000_0000_7FFF_FFFF;
            if (v < -64'sh0000_0000_8000_0000) return -64'sh0000_0000_8000_0000;
            return v;
        endfunction

        // interpolated table read; distances of 2.0 and beyond take the last entry
        function longint exp_at(longint d);
            longint pos;
            longint frac;
            longint a;
            longint b;
            longint idx;
            if (d >= 131072) return exp_tab[EXP_DEPTH_DEF];
            pos = d * EXP_DEPTH_DEF;
            idx = pos >>> 17;
            if (idx >= EXP_DEPTH_DEF) return exp_tab[EXP_DEPTH_DEF];
            frac = pos & 64'sh1FFFF;
            a = exp_tab[idx];
            b = exp_tab[idx + 1];
            if (a >= b) return a - (((a - b) * frac) >>> 17);
            return a + (((b - a) * frac) >>> 17);
        endfunction

        function void note_tick(t_in t);
            t_out   q;
            longint mv;
            longint midv;
            longint res;
            longint bid;
            longint ask;
            longint maxi;
            longint fill_dist;
            longint chance;
            longint nm;
            longint worth;
            bit     buy;
            bit     hit;
            mv   = t.price_move;
            midv = longint'(mid);
            res  = midv - longint'(skew_per_unit) * inv;
            bid  = res - longint'(half_width);
            ask  = res + longint'(half_width);
            maxi = longint'(inv_limit);
            buy  = 1'b0;
            hit  = 1'b0;
            if (t.arrival_draw < arrival_prob) begin
                if (t.informed_draw < informed_prob)
                    buy = (mv >= 0);
                else
                    buy = (t.side_draw < 16'd32768);
                fill_dist = buy ? ask - midv : midv - bid;
                if (fill_dist < 0) fill_dist = 0;
                chance = (longint'(fill_scale) * exp_at(fill_dist)) >>> 16;
                if (chance > 65536) chance = 65536;
                if (longint'(t.fill_draw) < chance) begin
                    // an order beyond the inventory limit leaves everything as it was
                    if (buy && inv > -maxi) begin
                        inv  -= 1;
                        cash = sat48(cash + ask - longint'(fee_per_fill));
                        hit  = 1'b1;
                        if (mv > 0) adverse += mv;
                    end else if (!buy && inv < maxi) begin
                        inv  += 1;
                        cash = sat48(cash - bid - longint'(fee_per_fill));
                        hit  = 1'b1;
                        if (mv < 0) adverse -= mv;
                    end
                    if (adverse > 64'sh0000_FFFF_FFFF_FFFF) adverse = 64'sh0000_FFFF_FFFF_FFFF;
                    if (hit && fills != 32'hFFFF_FFFF) fills++;
                end
            end
            nm = midv + mv;
            if (nm < longint'(MID_FLOOR)) nm = longint'(MID_FLOOR);
            if (nm > longint'(32'hFFFF_FFFF)) nm = longint'(32'hFFFF_FFFF);
            mid   = nm[31:0];
            worth = sat48(cash + inv * longint'(mid));

            q.bid_price    = sat32(bid);
            q.ask_price    = sat32(ask);
            q.filled       = hit;
            q.fill_side    = hit && buy;
            q.position     = inv[11:0];
            q.cash_balance = cash[47:0];
            q.fill_count   = fills;
            q.adverse_cost = adverse[47:0];
            q.midprice_out = mid;
            q.profit       = worth[47:0];
            pending_quotes.push_back(q);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH result %0d: %s", n_checked, msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
        endtask

        task check_quote(t_out g);
            t_out w;
            if (pending_quotes.size() == 0) begin
                report("result transfer with no tick pending");
                return;
            end
            w = pending_quotes.pop_front();
            n_checked++;
            check_field("bid_price", g.bid_price, w.bid_price);
            check_field("ask_price", g.ask_price, w.ask_price);
            check_field("filled", g.filled, w.filled);
            check_field("fill_side", g.fill_side, w.fill_side);
            check_field("position", g.position, w.position);
            check_field("cash_balance", g.cash_balance, w.cash_balance);
            check_field("fill_count", g.fill_count, w.fill_count);
            check_field("adverse_cost", g.adverse_cost, w.adverse_cost);
            check_field("midprice_out", g.midprice_out, w.midprice_out);
            check_field("profit", g.profit, w.profit);
        endtask

        task close();
            if (pending_quotes.size() != 0)
                report($sformatf("%0d ticks never produced a result", pending_quotes.size()));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    quote_scoreboard sb;
    int              hold_len = 0;
    bit              quiet    = 1'b0;

    market_maker_tick_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_quote(out_data);
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return $urandom_range(20, 50);
        if (k < 4) return $urandom_range(4, 10);
        if (k < 12) return 0;
        return $urandom_range(1, 3);
    endfunction

    initial begin
        bit run_ready;
        int run_left;
        run_ready = 1'b1;
        run_left  = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_len > 0) begin
                out_ready <= 1'b0;
                hold_len--;
            end else if (quiet) begin
                out_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_ready = ($urandom_range(0, 2) != 0);
                    run_left  = run_ready ? $urandom_range(1, 16) : pick_gap() + 1;
                end
                out_ready <= run_ready;
                run_left--;
            end
        end
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_tick(t_in d);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= d;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_tick(d);
        @(negedge clk);
    endtask

    task automatic tick(logic [23:0] mv, logic [15:0] arr, logic [15:0] inf,
                        logic [15:0] side, logic [15:0] fd);
        t_in d;
        d.price_move    = mv;
        d.arrival_draw  = arr;
        d.informed_draw = inf;
        d.side_draw     = side;
        d.fill_draw     = fd;
        push_tick(d);
    endtask

    // hold the input low until every pending tick has been answered
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending_quotes.size() != 0);
    endtask

    task automatic put_reg(t_reg_idx r, logic [31:0] v);
        cfg_index <= r;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(r, v);
        @(negedge clk);
    endtask

    task automatic close_writes();
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_setting(t_reg_idx r);
        int k;
        k = $urandom_range(0, 7);
        // full-width write: bits above the register width must drop
        if (k == 0) return $urandom;
        case (r)
            REG_HALF_WIDTH:
                case (k)
                    1:       return 0;
                    2:       return 131071;
                    3:       return 131072;
                    4:       return 20'hFFFFF;
                    default: return $urandom_range(0, 20000);
                endcase
            REG_SKEW_PER_UNIT, REG_FEE_PER_FILL:
                case (k)
                    1:       return 0;
                    2:       return 16'hFFFF;
                    default: return $urandom_range(0, 3000);
                endcase
            REG_INV_LIMIT:
                case (k)
                    1:       return 0;
                    2:       return 1023;
                    default: return $urandom_range(1, 12);
                endcase
            REG_START_MIDPRICE:
                case (k)
                    1:       return 0;
                    2:       return 654;
                    3:       return 655;
                    4:       return 32'hFFFF_FFFF;
                    default: return $urandom_range(65536, 20000000);
                endcase
            default:
                case (k)
                    1:       return 0;
                    2:       return 65536;
                    3:       return 17'h1FFFF;
                    default: return $urandom_range(32768, 65536);
                endcase
        endcase
    endfunction

    task automatic retune(bit every);
        t_reg_idx r;
        r = r.first();
        do begin
            if (every || $urandom_range(0, 3) == 0 ||
                (r != REG_START_MIDPRICE && $urandom_range(0, 1) == 1))
                put_reg(r, pick_setting(r));
            r = r.next();
        end while (r != r.first());
        close_writes();
    endtask

    // lean 1 pushes toward buys, lean 2 toward sells, 0 leaves the side free
    function automatic t_in make_tick(int lean);
        t_in d;
        case ($urandom_range(0, 9))
            0:       d.price_move = 24'($urandom);
            1:       d.price_move = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: d.price_move = 24'($urandom_range(0, 131072) - 65536);
        endcase
        d.arrival_draw  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8191));
        d.informed_draw = (lean != 0 && $urandom_range(0, 3) != 0) ? 16'hFFFF : 16'($urandom);
        case (lean)
            1:       d.side_draw = 16'($urandom_range(0, 32767));
            2:       d.side_draw = 16'($urandom_range(32768, 65535));
            default: d.side_draw = 16'($urandom);
        endcase
        d.fill_draw = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4095));
        return d;
    endfunction

    initial begin
        int lean;
        int waited;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: both sides, informed and not, draw boundaries, midprice floor
        tick(24'h000000, 16'd0,     16'hFFFF,  16'd0,     16'd0);
        tick(24'h000000, 16'd0,     16'hFFFF,  16'hFFFF,  16'd0);
        tick(24'h7FFFFF, 16'd0,     16'd0,     16'hFFFF,  16'd0);
        tick(24'h800000, 16'd0,     16'd0,     16'd0,     16'd0);
        tick(24'h800000, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
        tick(24'h7FFFFF, 16'd26213, 16'hFFFF,  16'd32767, 16'd0);
        tick(24'h000000, 16'd26214, 16'd0,     16'd0,     16'd0);
        tick(24'h000000, 16'd0,     16'd13106, 16'hFFFF,  16'd0);
        tick(24'hFFFFFF, 16'd0,     16'd13107, 16'd32768, 16'd0);
        tick(24'h0000FF, 16'd0,     16'hFFFF,  16'd0,     16'hFFFF);

        // far quotes, saturated midprice and quotes, chances above one
        drain();
        put_reg(REG_HALF_WIDTH, 32'h000F_FFFF);
        put_reg(REG_SKEW_PER_UNIT, 32'd0);
        put_reg(REG_ARRIVAL_PROB, 32'hFFFF_FFFF);
        put_reg(REG_INFORMED_PROB, 32'd0);
        put_reg(REG_FILL_SCALE, 32'h0001_FFFF);
        put_reg(REG_FEE_PER_FILL, 32'd65535);
        put_reg(REG_INV_LIMIT, 32'd1023);
        put_reg(REG_START_MIDPRICE, 32'hFFFF_FFFF);
        close_writes();
        tick(24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'd0,    16'd0);
        tick(24'h800000, 16'd0,    16'd0,    16'hFFFF, 16'd0);

        // zero limit blocks both sides; start midprice of zero floors
        drain();
        put_reg(REG_HALF_WIDTH, 32'd0);
        put_reg(REG_SKEW_PER_UNIT, 32'd65535);
        put_reg(REG_FILL_SCALE, 32'd65536);
        put_reg(REG_INV_LIMIT, 32'd0);
        put_reg(REG_START_MIDPRICE, 32'd0);
        close_writes();
        tick(24'h000000, 16'd0, 16'hFFFF, 16'd0,    16'd0);
        tick(24'h000000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);

        // sure fills run into the limit
        drain();
        put_reg(REG_SKEW_PER_UNIT, 32'd0);
        put_reg(REG_INV_LIMIT, 32'd3);
        close_writes();
        repeat (6) tick(24'h010000, 16'd12345, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // lowered limit: inventory above it stays until buys bring it down
        drain();
        put_reg(REG_INV_LIMIT, 32'd1);
        close_writes();
        tick(24'h000000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        tick(24'hFF0000, 16'd0, 16'hFFFF, 16'd0,    16'd0);
        tick(24'hFF0000, 16'd0, 16'hFFFF, 16'd0,    16'd0);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            retune(ph == 0);
            quiet = (ph == 4);
            lean  = $urandom_range(0, 2);
            for (int n = 0; n < 85; n++) begin
                // long receiver hold-off while ticks keep coming
                if (ph == 1 && n == 20) hold_len = 400;
                if (ph == 2 && n == 40) drain();
                push_tick(make_tick(lean));
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_quotes.size() != 0 && waited < 100000) begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
